// ----- rtl/core/mm4x4_pkg.sv -----
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
`default_nettype none
package mm4x4_pkg;

  localparam int LANES = 4;
  localparam int WORD_W = 32;
  localparam int IDX_W = 2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MUL = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [LANES-1:0] vec_t;
  typedef vec_t [LANES-1:0] mat_t;

  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    word_t data;
  } bwr_t;

endpackage
`default_nettype wire

// ----- rtl/core/matrix_multiply_4x4_top.sv -----
// Top level of the 4x4 signed Q16.16 matrix multiplier, C row = A row * B.
// A multiply transaction passes from the input register through the product register, sum register
// and saturated result register to the output.
// Throughput: one transaction per cycle; a stalled output holds the whole pipeline.
// Load transactions write B from the input register and give no output.
// Reset clears B to zero and empties the pipeline.
`default_nettype none
module matrix_multiply_4x4_top #(
  parameter int DIM = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // load_row[1:0], load_col[3:2], a0[35:4], a1[67:36], a2[99:68], a3[131:100], zero pad
  input  wire  [135:0] in_tdata,
  // action[0]
  input  wire  [0:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // c0[31:0], c1[63:32], c2[95:64], c3[127:96]
  output logic [127:0] out_tdata
);
  import mm4x4_pkg::*;

  logic en;
  logic v0_r, v1_r, v2_r, v3_r;
  logic act_r;
  logic [IDX_W-1:0] row_r, col_r;
  vec_t a_r;
  bwr_t bwr;
  mat_t bmat;
  vec_t c;

  assign en = !(v3_r && !out_tready);
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r && (act_r == ACT_MUL);
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act_r <= in_tuser[0];
      row_r <= in_tdata[1:0];
      col_r <= in_tdata[3:2];
      for (int j = 0; j < LANES; j++) begin
        a_r[j] <= in_tdata[4 + WORD_W*j +: WORD_W];
      end
    end
  end

  always_comb begin
    bwr.we = en && v0_r && (act_r == ACT_LOAD);
    bwr.row = row_r;
    bwr.col = col_r;
    bwr.data = a_r[0];
  end

  mm4x4_bstore #(.DIM(DIM)) u_bstore (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (bwr),
    .bmat (bmat)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    vec_t bcol;
    for (genvar j = 0; j < LANES; j++) begin : g_col
      assign bcol[j] = bmat[j][k];
    end

    mm4x4_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .en  (en),
      .a   (a_r),
      .bcol(bcol),
      .c   (c[k])
    );

    if (k < DIM) begin : g_live
      assign out_tdata[WORD_W*k +: WORD_W] = c[k];
    end else begin : g_zero
      assign out_tdata[WORD_W*k +: WORD_W] = '0;
    end
  end

  assign out_tvalid = v3_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v0_r && act_r == ACT_LOAD) |=> !v1_r)
    else $error("load transaction entered the result pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v1_r) && $stable(v2_r) && $stable(v0_r)))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// ----- rtl/core/mm4x4_bstore.sv -----
// Register store for the right-hand matrix B with single-element writes.
`default_nettype none
module mm4x4_bstore #(
  parameter int DIM = 4
) (
  input  wire             clk,
  input  wire             rst_n,
  input  mm4x4_pkg::bwr_t wr,
  output mm4x4_pkg::mat_t bmat
);
  import mm4x4_pkg::*;

  mat_t b_r;
  logic in_range;

  assign in_range = (int'(wr.row) < DIM) && (int'(wr.col) < DIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else if (wr.we && in_range) begin
      b_r[wr.row][wr.col] <= wr.data;
    end
  end

  assign bmat = b_r;

endmodule
`default_nettype wire

// ----- rtl/core/mm4x4_lane.sv -----
// One output column: registered products, registered sum, shift, saturate and registered result.
`default_nettype none
module mm4x4_lane #(
  parameter int FRAC_BITS = 16
) (
  input  wire              clk,
  input  wire              en,
  input  mm4x4_pkg::vec_t  a,
  input  mm4x4_pkg::vec_t  bcol,
  output mm4x4_pkg::word_t c
);
  import mm4x4_pkg::*;

  localparam int PW = 2 * WORD_W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MAXV = SW'(32'h7fff_ffff);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [PW-1:0] prod_r [LANES];
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] shifted;
  word_t res_r;
  word_t res_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < LANES; j++) begin
        prod_r[j] <= $signed(a[j]) * $signed(bcol[j]);
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < LANES; j++) begin
      sum_nxt = sum_nxt + SW'(prod_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  assign shifted = sum_r >>> FRAC_BITS;

  always_comb begin
    if (shifted > MAXV) begin
      res_nxt = word_t'(32'h7fff_ffff);
    end else if (shifted < MINV) begin
      res_nxt = word_t'(32'h8000_0000);
    end else begin
      res_nxt = shifted[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign c = res_r;

endmodule
`default_nettype wire
